@@ hdl/hbk_pkg.sv @@
`timescale 1ns / 1ps

package hbk_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int MOD_BITS   = 8;
    localparam int EV_BITS    = MOD_BITS + 2 * KEY_SLOTS;
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    localparam logic [7:0] FIRST_KEY_CODE_RESET = 8'd4;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_FIRST_KEY_CODE = 1'b0;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key0;
        logic [7:0] key1;
        logic [7:0] key2;
        logic [7:0] key3;
        logic [7:0] key4;
        logic [7:0] key5;
    } t_report;

    typedef struct packed {
        logic       is_modifier;
        logic [7:0] code;
        logic       pressed;
        logic       last;
    } t_key_event;

    // one classified report: which events fire, plus the data to build them
    typedef struct packed {
        logic [EV_BITS-1:0]          mask;
        logic [MOD_BITS-1:0]         mods;
        logic [KEY_SLOTS-1:0][7:0]   old_keys;
        logic [KEY_SLOTS-1:0][7:0]   new_keys;
    } t_job;

endpackage

@@ hdl/hbk_front.sv @@
`timescale 1ns / 1ps

module hbk_front import hbk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_report    i_report,
    input  logic [7:0] i_first_key_code,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [MOD_BITS-1:0]       r_prev_mods;
    logic [KEY_SLOTS-1:0][7:0] r_prev_keys;

    logic [KEY_SLOTS-1:0][7:0] keys;
    logic [KEY_SLOTS-1:0]      old_in_new;
    logic [KEY_SLOTS-1:0]      new_in_old;
    logic                      drop;
    logic [EV_BITS-1:0]        mask;

    always_comb begin
        keys[0] = i_report.key0;
        keys[1] = i_report.key1;
        keys[2] = i_report.key2;
        keys[3] = i_report.key3;
        keys[4] = i_report.key4;
        keys[5] = i_report.key5;

        drop = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (keys[i] != 8'd0 && keys[i] < i_first_key_code) begin
                drop = 1'b1;
            end
        end

        for (int i = 0; i < KEY_SLOTS; i++) begin
            old_in_new[i] = 1'b0;
            new_in_old[i] = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (keys[j] == r_prev_keys[i]) begin
                    old_in_new[i] = 1'b1;
                end
                if (r_prev_keys[j] == keys[i]) begin
                    new_in_old[i] = 1'b1;
                end
            end
        end

        mask[MOD_BITS-1:0] = r_prev_mods ^ i_report.modifiers;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            mask[MOD_BITS + 2*i]     = !old_in_new[i] && (r_prev_keys[i] >= i_first_key_code);
            mask[MOD_BITS + 2*i + 1] = !new_in_old[i] && (keys[i] >= i_first_key_code);
        end
    end

    always_comb begin
        o_job_push     = i_accept && !drop && (mask != '0);
        o_job.mask     = mask;
        o_job.mods     = i_report.modifiers;
        o_job.old_keys = r_prev_keys;
        o_job.new_keys = keys;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            r_prev_keys <= '0;
        end else if (i_accept && !drop) begin
            r_prev_mods <= i_report.modifiers;
            r_prev_keys <= keys;
        end
    end

endmodule

@@ hdl/hbk_jobq.sv @@
`timescale 1ns / 1ps

module hbk_jobq import hbk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job                  r_mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wr_ptr;
    logic [JOBQ_PTR_W-1:0] r_rd_ptr;
    logic [JOBQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/hbk_back.sv @@
`timescale 1ns / 1ps

module hbk_back import hbk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_key_event o_event
);

    logic               r_busy;
    t_job               r_job;
    logic               r_out_valid;
    t_key_event         r_out;

    logic [EV_BITS-1:0] onehot;
    logic [EV_BITS-1:0] rest;
    logic               advance;
    logic               load;
    t_key_event         ev;

    always_comb begin
        // lowest pending event first
        onehot  = r_job.mask & (~r_job.mask + 1'b1);
        rest    = r_job.mask & ~onehot;
        advance = r_busy && (!r_out_valid || i_pop);
        load    = !i_q_empty && (!r_busy || (advance && (rest == '0)));

        ev.is_modifier = |onehot[MOD_BITS-1:0];
        ev.pressed     = |(onehot[MOD_BITS-1:0] & r_job.mods);
        ev.code        = '0;
        ev.last        = (rest == '0);
        for (int m = 0; m < MOD_BITS; m++) begin
            if (onehot[m]) begin
                ev.code = ev.code | 8'(m);
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (onehot[MOD_BITS + 2*i]) begin
                ev.code = ev.code | r_job.old_keys[i];
            end
            if (onehot[MOD_BITS + 2*i + 1]) begin
                ev.code    = ev.code | r_job.new_keys[i];
                ev.pressed = 1'b1;
            end
        end
    end

    assign o_q_pop = load;
    assign o_empty = !r_out_valid;
    assign o_event = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end else if (advance) begin
            r_job.mask <= rest;
        end
        if (advance) begin
            r_out <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (advance && (rest == '0)) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/hid_boot_keyboard_report_diff_core.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                         beat
// report    in         push & !full                      i_report (t_report)
// event     out        pop & !empty                      o_event (t_key_event)
// config    in         psel & penable & pwrite & pready  pwdata at paddr
//
// a report is classified in the cycle it is accepted; the back end then
// emits its events (0 to 20) one per cycle while the receiver keeps popping,
// through the single event output register
// a two-entry job queue lets new reports be taken while events drain
// reset (synchronous, active low) clears the stored report and all queues

module hid_boot_keyboard_report_diff_core import hbk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_report     i_report,
    input  logic        pop,
    output logic        empty,
    output t_key_event  o_event,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_first_key_code;

    logic accept;
    logic job_push;
    t_job job_in;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job job_out;

    assign pready = 1'b1;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign prdata = (paddr[2] == CFG_IDX_FIRST_KEY_CODE) ? {24'd0, r_first_key_code} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_key_code <= FIRST_KEY_CODE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == CFG_IDX_FIRST_KEY_CODE) begin
            r_first_key_code <= pwdata[7:0];
        end
    end

    hbk_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_report         (i_report),
        .i_first_key_code (r_first_key_code),
        .o_job_push       (job_push),
        .o_job            (job_in)
    );

    hbk_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    hbk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (job_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_event   (o_event)
    );

`ifndef ASSERT_OFF
    a_no_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !q_full)
        else $error("job queue overflow");

    a_job_has_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> (job_in.mask != '0))
        else $error("queued report carries no events");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from empty queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> empty)
        else $error("event pending right after reset");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hbk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;

    class key_event_board;
        logic [7:0] first_key;
        logic [7:0] prev_mods;
        logic [7:0] prev_keys[KEY_SLOTS];
        t_key_event expected_events[$];
        int mismatches;

        function new();
            first_key = FIRST_KEY_CODE_RESET;
            prev_mods = '0;
            foreach (prev_keys[i]) prev_keys[i] = '0;
            mismatches = 0;
        endfunction

        function bit holds_code(logic [7:0] set[KEY_SLOTS], logic [7:0] v);
            foreach (set[j]) begin
                if (set[j] == v) return 1'b1;
            end
            return 1'b0;
        endfunction

        // work out the key events of one accepted report
        function void note_report(t_report r);
            logic [7:0] keys[KEY_SLOTS];
            t_key_event ev;
            t_key_event events[$];
            keys[0] = r.key0;
            keys[1] = r.key1;
            keys[2] = r.key2;
            keys[3] = r.key3;
            keys[4] = r.key4;
            keys[5] = r.key5;
            // rollover or error report is dropped
            foreach (keys[i]) begin
                if (keys[i] != 8'd0 && keys[i] < first_key) return;
            end
            for (int b = 0; b < MOD_BITS; b++) begin
                if (prev_mods[b] != r.modifiers[b]) begin
                    ev.is_modifier = 1'b1;
                    ev.code = 8'(b);
                    ev.pressed = r.modifiers[b];
                    ev.last = 1'b0;
                    events.push_back(ev);
                end
            end
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (!holds_code(keys, prev_keys[s]) && prev_keys[s] >= first_key) begin
                    ev.is_modifier = 1'b0;
                    ev.code = prev_keys[s];
                    ev.pressed = 1'b0;
                    ev.last = 1'b0;
                    events.push_back(ev);
                end
                if (!holds_code(prev_keys, keys[s]) && keys[s] >= first_key) begin
                    ev.is_modifier = 1'b0;
                    ev.code = keys[s];
                    ev.pressed = 1'b1;
                    ev.last = 1'b0;
                    events.push_back(ev);
                end
            end
            if (events.size() > 0) events[events.size() - 1].last = 1'b1;
            foreach (events[i]) expected_events.push_back(events[i]);
            prev_mods = r.modifiers;
            prev_keys = keys;
        endfunction

        function void check_event(t_key_event got);
            t_key_event want;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event mod=%0b code=%0d pressed=%0b last=%0b",
                         $time, got.is_modifier, got.code, got.pressed, got.last);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            if (got.is_modifier !== want.is_modifier || got.code !== want.code ||
                got.pressed !== want.pressed || got.last !== want.last) begin
                $display("%0t: event mismatch: expected mod=%0b code=%0d pressed=%0b last=%0b",
                         $time, want.is_modifier, want.code, want.pressed, want.last);
                $display("%0t:                 actual   mod=%0b code=%0d pressed=%0b last=%0b",
                         $time, got.is_modifier, got.code, got.pressed, got.last);
                mismatches++;
            end
        endfunction

        function int waiting();
            return expected_events.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_report     i_report;
    logic        pop;
    logic        empty;
    t_key_event  o_event;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_event_board sb;
    bit hold_req;
    bit calm;
    int read_errors;
    int cycle_count;

    hid_boot_keyboard_report_diff_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_report (i_report),
        .pop      (pop),
        .empty    (empty),
        .o_event  (o_event),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_event(o_event);
    end

    // receiver side
    initial begin
        int burst;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 15);
                pop <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_report mk(logic [7:0] m, logic [7:0] k0, logic [7:0] k1,
                                   logic [7:0] k2, logic [7:0] k3, logic [7:0] k4,
                                   logic [7:0] k5);
        t_report r;
        r.modifiers = m;
        r.key0 = k0;
        r.key1 = k1;
        r.key2 = k2;
        r.key3 = k3;
        r.key4 = k4;
        r.key5 = k5;
        return r;
    endfunction

    function automatic logic [7:0] real_key();
        return 8'(sb.first_key + $urandom_range(0, 255 - sb.first_key));
    endfunction

    // mostly small edits of the held report, some fresh, some broken
    function automatic t_report make_report();
        logic [7:0] m;
        logic [7:0] k[KEY_SLOTS];
        int kind;
        int fk;
        int slot;
        fk = sb.first_key;
        m = sb.prev_mods;
        k = sb.prev_keys;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            repeat ($urandom_range(1, 3)) begin
                slot = $urandom_range(0, KEY_SLOTS - 1);
                k[slot] = ($urandom_range(0, 2) == 0) ? 8'd0 : real_key();
            end
            if ($urandom_range(0, 1) == 1) m = m ^ 8'($urandom_range(1, 255));
        end else if (kind < 65) begin
            // same report again
        end else if (kind < 80) begin
            m = 8'($urandom_range(0, 255));
            foreach (k[i]) k[i] = ($urandom_range(0, 2) == 0) ? 8'd0 : real_key();
        end else if (kind < 92 && fk > 1) begin
            if ($urandom_range(0, 2) == 0) begin
                foreach (k[i]) k[i] = 8'd1;
            end else begin
                slot = $urandom_range(0, KEY_SLOTS - 1);
                k[slot] = 8'($urandom_range(1, fk - 1));
            end
        end else begin
            m = 8'($urandom_range(0, 255));
            foreach (k[i]) k[i] = 8'($urandom_range(0, 255));
        end
        return mk(m, k[0], k[1], k[2], k[3], k[4], k[5]);
    endfunction

    task automatic send_report(t_report r);
        int gap;
        @(negedge i_clk);
        push <= 1'b1;
        i_report <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_report(r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        repeat (count) send_report(make_report());
    endtask

    task automatic reg_write(logic idx, logic [7:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == CFG_IDX_FIRST_KEY_CODE) sb.first_key = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check();
        logic [31:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {CFG_IDX_FIRST_KEY_CODE, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        if (got !== {24'd0, sb.first_key}) begin
            $display("%0t: register read mismatch: expected %0d, actual %0d",
                     $time, sb.first_key, got);
            read_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering reports, wait for all events, then idle before the next test
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        hold_req = 1'b0;
        calm = 1'b0;
        read_errors = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_report = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reg_check();

        send_report(mk(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'hA5, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
        send_report(mk(8'hA5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10));
        send_report(mk(8'h00, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
        send_report(mk(8'h00, 8'd5, 8'd6, 8'd3, 8'd8, 8'd9, 8'd10));
        send_report(mk(8'h5A, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16));
        send_report(mk(8'h5A, 8'd255, 8'd255, 8'd0, 8'd0, 8'd12, 8'd12));
        send_report(mk(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_report(mk(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_report(mk(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        settle();

        // write to the unused index must not change the register
        reg_write(~CFG_IDX_FIRST_KEY_CODE, 8'h20);
        reg_check();
        reg_write(CFG_IDX_FIRST_KEY_CODE, 8'd0);
        reg_check();
        send_report(mk(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'h00, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'h01, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6));
        send_report(mk(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_random(25);
        settle();

        reg_write(CFG_IDX_FIRST_KEY_CODE, 8'd255);
        reg_check();
        send_report(mk(8'h80, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'h80, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_report(mk(8'h00, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        send_random(15);
        settle();

        reg_write(CFG_IDX_FIRST_KEY_CODE, 8'd1);
        reg_check();
        send_random(25);
        settle();

        // receiver stops for a long stretch so the block fills and stalls push
        reg_write(CFG_IDX_FIRST_KEY_CODE, 8'($urandom_range(2, 60)));
        reg_check();
        hold_req = 1'b1;
        send_random(35);
        settle();

        reg_write(CFG_IDX_FIRST_KEY_CODE, FIRST_KEY_CODE_RESET);
        reg_check();
        calm = 1'b1;
        send_random(15);
        @(negedge i_clk);
        push <= 1'b0;

        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.waiting() == 0 && read_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/hbk_pkg.sv
hdl/hbk_front.sv
hdl/hbk_jobq.sv
hdl/hbk_back.sv
hdl/hid_boot_keyboard_report_diff_core.sv
tb/tb_top.sv
